// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on the rising clock, off in reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never hold on a rising clock edge.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: rtl/deq_pkg.sv
// Package: widths, codes, queue entry type and ring index helper for the deque.
`timescale 1ns / 1ps
package deq_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int ACT_W   = 3;
  localparam int POS_W   = 6;
  localparam int NS_W    = 7;
  localparam int ST_W    = 3;
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_RESIZE     = 3'd4,
    ACT_READ       = 3'd5,
    ACT_WRITE      = 3'd6,
    ACT_DUMP       = 3'd7
  } act_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_RANGE = 3'd3,
    ST_SIZE  = 3'd4
  } st_t;

  typedef enum logic [1:0] {
    OP_STATUS,
    OP_WRITE,
    OP_READ,
    OP_DUMP
  } op_kind_t;

  // One decoded command handed from the front end to the back end.
  typedef struct packed {
    op_kind_t                 kind;
    st_t                      st;
    logic [IDX_W-1:0]         idx;    // slot, or head for a dump
    logic [CNT_W-1:0]         cnt;    // element count for a dump
    logic [DATA_W-1:0]        value;
    logic                     vbit;   // slot valid mark at command time
  } op_t;

  function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) sum = sum - (CNT_W+1)'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

endpackage

// File: rtl/deq_front.sv
// Front end: accepts commands, checks them against head/count, keeps valid marks.
`timescale 1ns / 1ps
module deq_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [deq_pkg::ACT_W-1:0]     in_action,
  input  logic signed [deq_pkg::DATA_W-1:0] in_value,
  input  logic [deq_pkg::POS_W-1:0]     in_position,
  input  logic [deq_pkg::NS_W-1:0]      in_new_size,
  input  logic                          q_full,
  output logic                          q_push,
  output deq_pkg::op_t                  q_op,
  input  logic                          dump_done,
  output logic [deq_pkg::DEPTH-1:0]     slot_vld
);
  import deq_pkg::*;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic             dump_pend_r, dump_pend_nxt;

  logic             accept;
  logic             full, empty;
  logic [IDX_W-1:0] idx_back, idx_last, idx_pos, head_dec, head_inc;
  logic [CNT_W-1:0] ns_c, lo, hi, pos_c;
  logic [CNT_W-1:0] off [DEPTH];
  logic             pos_bad, ns_bad;

  assign busy     = q_full | dump_pend_r;
  assign accept   = start & ~busy;
  assign slot_vld = vld_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pos_c    = CNT_W'(in_position);
  assign ns_c     = CNT_W'(in_new_size);
  assign pos_bad  = ({{CNT_W{1'b0}}, in_position} >= {{POS_W{1'b0}}, count_r});
  assign ns_bad   = ({{CNT_W{1'b0}}, in_new_size} > (NS_W+CNT_W)'(DEPTH));
  assign idx_back = ring_idx(head_r, count_r);
  assign idx_last = ring_idx(head_r, count_r - 1'b1);
  assign idx_pos  = ring_idx(head_r, pos_c);
  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign lo       = (ns_c < count_r) ? ns_c : count_r;
  assign hi       = (ns_c < count_r) ? count_r : ns_c;

  // Offset of each slot from the front of the ring.
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      if (IDX_W'(j) >= head_r) off[j] = CNT_W'(IDX_W'(j) - head_r);
      else                     off[j] = CNT_W'(CNT_W'(j) + CNT_W'(DEPTH) - CNT_W'(head_r));
    end
  end

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    vld_nxt       = vld_r;
    dump_pend_nxt = dump_pend_r & ~dump_done;
    q_push        = 1'b0;
    q_op.kind     = OP_STATUS;
    q_op.st       = ST_OK;
    q_op.idx      = '0;
    q_op.cnt      = '0;
    q_op.value    = in_value;
    q_op.vbit     = 1'b0;
    if (accept) begin
      q_push = 1'b1;
      unique case (act_t'(in_action))
        ACT_PUSH_BACK: begin
          if (full) q_op.st = ST_FULL;
          else begin
            q_op.kind         = OP_WRITE;
            q_op.idx          = idx_back;
            vld_nxt[idx_back] = 1'b1;
            count_nxt         = count_r + 1'b1;
          end
        end
        ACT_PUSH_FRONT: begin
          if (full) q_op.st = ST_FULL;
          else begin
            q_op.kind         = OP_WRITE;
            q_op.idx          = head_dec;
            vld_nxt[head_dec] = 1'b1;
            head_nxt          = head_dec;
            count_nxt         = count_r + 1'b1;
          end
        end
        ACT_POP_FRONT: begin
          if (empty) q_op.st = ST_EMPTY;
          else begin
            vld_nxt[head_r] = 1'b0;
            head_nxt        = head_inc;
            count_nxt       = count_r - 1'b1;
          end
        end
        ACT_POP_BACK: begin
          if (empty) q_op.st = ST_EMPTY;
          else begin
            vld_nxt[idx_last] = 1'b0;
            count_nxt         = count_r - 1'b1;
          end
        end
        ACT_RESIZE: begin
          if (ns_bad) q_op.st = ST_SIZE;
          else begin
            for (int j = 0; j < DEPTH; j++) begin
              if (off[j] >= lo && off[j] < hi) vld_nxt[j] = 1'b0;
            end
            count_nxt = ns_c;
          end
        end
        ACT_READ: begin
          if (pos_bad) q_op.st = ST_RANGE;
          else begin
            q_op.kind = OP_READ;
            q_op.idx  = idx_pos;
            q_op.vbit = vld_r[idx_pos];
          end
        end
        ACT_WRITE: begin
          if (pos_bad) q_op.st = ST_RANGE;
          else begin
            q_op.kind        = OP_WRITE;
            q_op.idx         = idx_pos;
            vld_nxt[idx_pos] = 1'b1;
          end
        end
        ACT_DUMP: begin
          if (empty) q_op.st = ST_EMPTY;
          else begin
            q_op.kind     = OP_DUMP;
            q_op.idx      = head_r;
            q_op.cnt      = count_r;
            dump_pend_nxt = 1'b1;
          end
        end
        default: q_op.st = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      vld_r       <= '0;
      dump_pend_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      vld_r       <= vld_nxt;
      dump_pend_r <= dump_pend_nxt;
    end
  end

endmodule

// File: rtl/deq_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module deq_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  deq_pkg::op_t push_op,
  input  logic         pop,
  output deq_pkg::op_t head_op,
  output logic         empty,
  output logic         full
);
  import deq_pkg::*;

  op_t             ent_r [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] cnt_r;

  assign head_op = ent_r[rd_ptr_r];
  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == QC_W'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// File: rtl/deq_back.sv
// Back end: slot memory, dump walker and result beat register.
`timescale 1ns / 1ps
module deq_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  deq_pkg::op_t                      q_op,
  output logic                              q_pop,
  input  logic [deq_pkg::DEPTH-1:0]         slot_vld,
  output logic                              dump_done,
  output logic                              out_strobe,
  output logic signed [deq_pkg::DATA_W-1:0] out_data,
  output logic [deq_pkg::ST_W-1:0]          out_status,
  output logic                              out_last
);
  import deq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  logic             dumping_r, dumping_nxt;
  logic [IDX_W-1:0] d_base_r, d_base_nxt;
  logic [CNT_W-1:0] d_cnt_r, d_cnt_nxt;
  logic [CNT_W-1:0] d_i_r, d_i_nxt;

  logic              iss_vld, iss_we, iss_re, iss_vb, iss_last;
  logic [IDX_W-1:0]  iss_idx;
  st_t               iss_st;

  logic              s1_vld_r, s1_re_r, s1_vb_r, s1_last_r;
  st_t               s1_st_r;
  logic [DATA_W-1:0] rd_r;

  always_comb begin
    dumping_nxt = dumping_r;
    d_base_nxt  = d_base_r;
    d_cnt_nxt   = d_cnt_r;
    d_i_nxt     = d_i_r;
    q_pop       = 1'b0;
    dump_done   = 1'b0;
    iss_vld     = 1'b0;
    iss_we      = 1'b0;
    iss_re      = 1'b0;
    iss_vb      = 1'b0;
    iss_last    = 1'b1;
    iss_idx     = q_op.idx;
    iss_st      = ST_OK;
    if (dumping_r) begin
      iss_vld     = 1'b1;
      iss_re      = 1'b1;
      iss_idx     = ring_idx(d_base_r, d_i_r);
      iss_vb      = slot_vld[iss_idx];
      iss_last    = (d_i_r == d_cnt_r - 1'b1);
      dump_done   = iss_last;
      dumping_nxt = ~iss_last;
      d_i_nxt     = d_i_r + 1'b1;
    end else if (!q_empty) begin
      q_pop   = 1'b1;
      iss_vld = 1'b1;
      iss_st  = q_op.st;
      unique case (q_op.kind)
        OP_STATUS: iss_last = 1'b1;
        OP_WRITE:  iss_we = 1'b1;
        OP_READ: begin
          iss_re = 1'b1;
          iss_vb = q_op.vbit;
        end
        OP_DUMP: begin
          iss_re      = 1'b1;
          iss_vb      = slot_vld[q_op.idx];
          iss_last    = (q_op.cnt == CNT_W'(1));
          dump_done   = iss_last;
          dumping_nxt = ~iss_last;
          d_base_nxt  = q_op.idx;
          d_cnt_nxt   = q_op.cnt;
          d_i_nxt     = CNT_W'(1);
        end
        default: iss_last = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (iss_we) mem[iss_idx] <= q_op.value;
    if (iss_re) rd_r <= mem[iss_idx];
  end

  always_ff @(posedge clk) begin
    s1_re_r   <= iss_re;
    s1_vb_r   <= iss_vb;
    s1_last_r <= iss_last;
    s1_st_r   <= iss_st;
    d_base_r  <= d_base_nxt;
    d_cnt_r   <= d_cnt_nxt;
    d_i_r     <= d_i_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dumping_r <= 1'b0;
      s1_vld_r  <= 1'b0;
    end else begin
      dumping_r <= dumping_nxt;
      s1_vld_r  <= iss_vld;
    end
  end

  assign out_strobe = s1_vld_r;
  assign out_data   = (s1_re_r && s1_vb_r) ? signed'(rd_r) : '0;
  assign out_status = s1_st_r;
  assign out_last   = s1_last_r;

endmodule

// File: rtl/double_ended_queue.sv
// Top level of the double-ended queue of signed 32-bit words.
//
// Commands enter on the in_ ports and are taken at a rising edge with start
// high and busy low. Each command yields one result beat on the out_ ports,
// a dump yields one beat per element from front to back, and out_last marks
// the final beat of a command. out_strobe flags a beat for exactly one cycle;
// the receiver has no way to stall, so beats are never held.
// A beat comes from its command through the command queue, then the memory
// access with registered read data. A two-entry command queue sits
// between the checking front end and the memory back end; commands may be
// taken one per cycle while the queue has room. A dump keeps busy high
// until its last slot read is issued, with one memory read per cycle.
// Synchronous active-low reset empties the deque, clears all slot valid
// marks and the command queue; slot contents are not cleared and read as
// zero until written.
`timescale 1ns / 1ps
module double_ended_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [deq_pkg::ACT_W-1:0]         in_action,
  input  logic signed [deq_pkg::DATA_W-1:0] in_value,
  input  logic [deq_pkg::POS_W-1:0]         in_position,
  input  logic [deq_pkg::NS_W-1:0]          in_new_size,
  output logic                              out_strobe,
  output logic signed [deq_pkg::DATA_W-1:0] out_data,
  output logic [deq_pkg::ST_W-1:0]          out_status,
  output logic                              out_last
);
  import deq_pkg::*;

  logic             q_full, q_empty, q_push, q_pop, dump_done;
  op_t              push_op, head_op;
  logic [DEPTH-1:0] slot_vld;

  deq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_action   (in_action),
    .in_value    (in_value),
    .in_position (in_position),
    .in_new_size (in_new_size),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_op        (push_op),
    .dump_done   (dump_done),
    .slot_vld    (slot_vld)
  );

  deq_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head_op (head_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  deq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_op       (head_op),
    .q_pop      (q_pop),
    .slot_vld   (slot_vld),
    .dump_done  (dump_done),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule

// File: rtl/deq_checker.sv
// Port-level checker for the deque, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module deq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_strobe,
  input logic signed [deq_pkg::DATA_W-1:0] out_data,
  input logic [deq_pkg::ST_W-1:0]          out_status,
  input logic                              out_last
);
  import deq_pkg::*;

  `ASSERT_NEVER(a_status_code, clk, rst_n, out_strobe && (out_status > ST_SIZE), "bad status code")
  `ASSERT_CLK(a_err_no_data, clk, rst_n, (out_strobe && out_status != ST_OK) |-> (out_data == '0), "data on error beat")
  `ASSERT_CLK(a_err_is_last, clk, rst_n, (out_strobe && out_status != ST_OK) |-> out_last, "error beat not last")
  `ASSERT_CLK(a_dump_burst, clk, rst_n, (out_strobe && !out_last) |=> out_strobe, "gap inside dump burst")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for the double-ended queue: command driver, beat monitor, predictor.
`timescale 1ns / 1ps
module tb_top;
  import deq_pkg::*;

  localparam int N_ITEMS  = 430;
  localparam int TAIL     = 40;
  localparam int DRAIN_AT = 250;

  typedef struct {
    act_t               action;
    logic signed [31:0] value;
    logic [POS_W-1:0]   position;
    logic [NS_W-1:0]    new_size;
    bit                 drain;
  } cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    st_t                      status;
    logic                     last;
  } beat_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [ACT_W-1:0]         in_action = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic [NS_W-1:0]          in_new_size = '0;
  logic                     out_strobe;
  logic signed [DATA_W-1:0] out_data;
  logic [ST_W-1:0]          out_status;
  logic                     out_last;

  double_ended_queue u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_action   (in_action),
    .in_value    (in_value),
    .in_position (in_position),
    .in_new_size (in_new_size),
    .out_strobe  (out_strobe),
    .out_data    (out_data),
    .out_status  (out_status),
    .out_last    (out_last)
  );

  always #5 clk = ~clk;

  cmd_t  pending[$];
  cmd_t  cur_cmd;
  beat_t exp_beats[$];
  beat_t want;
  int    gap_left = 0;

  // predicted deque contents
  logic [DATA_W-1:0] dq_word [DEPTH];
  bit                dq_valid [DEPTH];
  logic [IDX_W-1:0]  dq_head = '0;
  int unsigned       dq_count = 0;

  // stimulus-side shadow: head, count and which slots were ever written
  int unsigned g_head = 0;
  int unsigned g_count = 0;
  bit          g_written [DEPTH];

  int n_errors = 0;
  int n_cmds = 0;
  int n_dumps = 0;
  int n_beats = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_range = 0;
  int n_size = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    n_errors++;
    $display("MISMATCH %s: got %h want %h (beat %0d)", what, got, exp_val, n_beats);
  endtask

  function automatic void add_beat(input logic [DATA_W-1:0] d, input st_t s, input logic l);
    beat_t b;
    b.data = d;
    b.status = s;
    b.last = l;
    exp_beats.insert(exp_beats.size(), b);
  endfunction

  function automatic int unsigned dq_slot(input int unsigned pos);
    return (int'(dq_head) + pos) % DEPTH;
  endfunction

  task automatic deque_apply(input cmd_t c);
    int unsigned ix;
    int unsigned lo;
    int unsigned hi;
    n_cmds++;
    case (c.action) inside
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (dq_count >= DEPTH) begin
          add_beat('0, ST_FULL, 1'b1);
        end else begin
          if (c.action == ACT_PUSH_FRONT) begin
            dq_head = dq_head - 1'b1;
            ix = dq_head;
          end else begin
            ix = dq_slot(dq_count);
          end
          dq_word[ix] = c.value;
          dq_valid[ix] = 1'b1;
          dq_count++;
          add_beat('0, ST_OK, 1'b1);
        end
      end
      ACT_POP_FRONT: begin
        if (dq_count == 0) begin
          add_beat('0, ST_EMPTY, 1'b1);
        end else begin
          dq_valid[dq_head] = 1'b0;
          dq_head = dq_head + 1'b1;
          dq_count--;
          add_beat('0, ST_OK, 1'b1);
        end
      end
      ACT_POP_BACK: begin
        if (dq_count == 0) begin
          add_beat('0, ST_EMPTY, 1'b1);
        end else begin
          dq_count--;
          dq_valid[dq_slot(dq_count)] = 1'b0;
          add_beat('0, ST_OK, 1'b1);
        end
      end
      ACT_RESIZE: begin
        if (c.new_size > DEPTH) begin
          add_beat('0, ST_SIZE, 1'b1);
        end else begin
          lo = (c.new_size < dq_count) ? c.new_size : dq_count;
          hi = (c.new_size < dq_count) ? dq_count : c.new_size;
          for (ix = lo; ix < hi; ix++) dq_valid[dq_slot(ix)] = 1'b0;
          dq_count = c.new_size;
          add_beat('0, ST_OK, 1'b1);
        end
      end
      ACT_READ: begin
        if (c.position >= dq_count) begin
          add_beat('0, ST_RANGE, 1'b1);
        end else begin
          ix = dq_slot(c.position);
          add_beat(dq_valid[ix] ? dq_word[ix] : '0, ST_OK, 1'b1);
        end
      end
      ACT_WRITE: begin
        if (c.position >= dq_count) begin
          add_beat('0, ST_RANGE, 1'b1);
        end else begin
          ix = dq_slot(c.position);
          dq_word[ix] = c.value;
          dq_valid[ix] = 1'b1;
          add_beat('0, ST_OK, 1'b1);
        end
      end
      default: begin
        n_dumps++;
        if (dq_count == 0) begin
          add_beat('0, ST_EMPTY, 1'b1);
        end else begin
          for (lo = 0; lo < dq_count; lo++) begin
            ix = dq_slot(lo);
            add_beat(dq_valid[ix] ? dq_word[ix] : '0, ST_OK, (lo + 1 == dq_count));
          end
        end
      end
    endcase
  endtask

  // Grow requests are trimmed so that no element ever maps to a slot never written.
  task automatic queue_cmd(input act_t a, input logic [31:0] v, input int unsigned pos,
                           input int unsigned ns, input bit drain);
    cmd_t        c;
    int unsigned k;
    if (a == ACT_RESIZE && ns <= DEPTH && ns > g_count) begin
      k = g_count;
      while (k < ns && g_written[(g_head + k) % DEPTH]) k++;
      ns = k;
    end
    c.action = a;
    c.value = v;
    c.position = pos[POS_W-1:0];
    c.new_size = ns[NS_W-1:0];
    c.drain = drain;
    pending.insert(pending.size(), c);
    case (a)
      ACT_PUSH_BACK: if (g_count < DEPTH) begin
        g_written[(g_head + g_count) % DEPTH] = 1'b1;
        g_count++;
      end
      ACT_PUSH_FRONT: if (g_count < DEPTH) begin
        g_head = (g_head + DEPTH - 1) % DEPTH;
        g_written[g_head] = 1'b1;
        g_count++;
      end
      ACT_POP_FRONT: if (g_count > 0) begin
        g_head = (g_head + 1) % DEPTH;
        g_count--;
      end
      ACT_POP_BACK: if (g_count > 0) g_count--;
      ACT_RESIZE: if (ns <= DEPTH) g_count = ns;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 11))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned rand_pos();
    if (g_count > 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, g_count - 1);
    return $urandom_range(0, 63);
  endfunction

  function automatic int unsigned rand_size();
    case ($urandom_range(0, 9))
      0: return $urandom_range(65, 127);
      1: return $urandom_range(0, 1) ? 64 : 0;
      default: return $urandom_range(0, 64);
    endcase
  endfunction

  function automatic act_t pick_action(input int mode);
    int push_w;
    int pop_w;
    int r;
    int r2;
    push_w = (mode == 0) ? 55 : (mode == 1) ? 10 : 25;
    pop_w  = (mode == 0) ? 10 : (mode == 1) ? 55 : 25;
    r = $urandom_range(0, 99);
    if (r < push_w) return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    if (r < push_w + pop_w) return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
    r2 = $urandom_range(0, 99);
    if (r2 < 35) return ACT_READ;
    if (r2 < 65) return ACT_WRITE;
    if (r2 < 82) return ACT_RESIZE;
    return ACT_DUMP;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) deque_apply(cur_cmd);
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending.size() == 0) begin
        start <= 1'b0;
      end else if (pending[0].drain && exp_beats.size() != 0) begin
        start <= 1'b0;
      end else begin
        cur_cmd = pending[0];
        pending.delete(0);
        in_action <= cur_cmd.action;
        in_value <= cur_cmd.value;
        in_position <= cur_cmd.position;
        in_new_size <= cur_cmd.new_size;
        start <= 1'b1;
        if (pending.size() > TAIL && $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 17);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      n_beats++;
      case (out_status)
        ST_FULL:  n_full++;
        ST_EMPTY: n_empty++;
        ST_RANGE: n_range++;
        ST_SIZE:  n_size++;
        default: ;
      endcase
      if (exp_beats.size() == 0) begin
        report_mismatch("unexpected beat", out_data, '0);
      end else begin
        want = exp_beats[0];
        exp_beats.delete(0);
        if (out_data !== want.data) report_mismatch("data", out_data, want.data);
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_last !== want.last) report_mismatch("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  initial begin
    int mode;
    int seg_len;
    queue_cmd(ACT_POP_FRONT, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_POP_BACK, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_DUMP, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_READ, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_WRITE, 32'hffff_ffff, 63, 0, 1'b0);
    queue_cmd(ACT_RESIZE, 32'h0, 0, 127, 1'b0);
    queue_cmd(ACT_RESIZE, 32'h0, 0, 65, 1'b0);
    queue_cmd(ACT_PUSH_BACK, 32'h7fff_ffff, 0, 0, 1'b1);
    queue_cmd(ACT_PUSH_FRONT, 32'h8000_0000, 0, 0, 1'b0);
    queue_cmd(ACT_PUSH_BACK, 32'hffff_ffff, 0, 0, 1'b0);
    queue_cmd(ACT_PUSH_FRONT, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_READ, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_READ, 32'h0, 3, 0, 1'b0);
    queue_cmd(ACT_READ, 32'h0, 4, 0, 1'b0);
    queue_cmd(ACT_POP_BACK, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_POP_FRONT, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_RESIZE, 32'h0, 0, 3, 1'b0);
    queue_cmd(ACT_READ, 32'h0, 2, 0, 1'b0);
    queue_cmd(ACT_WRITE, 32'h5a5a_5a5a, 2, 0, 1'b0);
    queue_cmd(ACT_DUMP, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_RESIZE, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_DUMP, 32'h0, 0, 0, 1'b0);

    // fill to full with random content, overflow, read, write and dump, then the size extremes
    while (g_count < DEPTH)
      queue_cmd($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, rand_word(),
                $urandom_range(0, 63), $urandom_range(0, 127), 1'b0);
    queue_cmd(ACT_PUSH_BACK, rand_word(), 0, 0, 1'b0);
    queue_cmd(ACT_PUSH_FRONT, rand_word(), 0, 0, 1'b0);
    queue_cmd(ACT_READ, 32'h0, 63, 0, 1'b0);
    queue_cmd(ACT_WRITE, rand_word(), 0, 0, 1'b0);
    queue_cmd(ACT_DUMP, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_RESIZE, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_RESIZE, 32'h0, 0, 64, 1'b0);
    queue_cmd(ACT_DUMP, 32'h0, 0, 0, 1'b0);
    queue_cmd(ACT_RESIZE, 32'h0, 0, 64, 1'b0);

    while (pending.size() < N_ITEMS) begin
      mode = $urandom_range(0, 2);
      seg_len = $urandom_range(20, 50);
      while (seg_len > 0 && pending.size() < N_ITEMS) begin
        queue_cmd(pick_action(mode), rand_word(), rand_pos(), rand_size(),
                  pending.size() == DRAIN_AT);
        seg_len--;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || start) @(posedge clk);
    while (exp_beats.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d commands incl. %0d dumps, %0d result beats checked",
             n_cmds, n_dumps, n_beats);
    $display("status beats seen: full %0d, empty %0d, range %0d, size %0d",
             n_full, n_empty, n_range, n_size);
    if (n_errors == 0) begin
      $display("double_ended_queue regression: pass");
    end else begin
      $display("double_ended_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("double_ended_queue regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_front.sv
rtl/deq_queue.sv
rtl/deq_back.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
dv/tb_top.sv
